// ----- sv/ufpe_pkg.sv -----
// Package for the URL form percent encoder.
// Holds the work descriptor type, character constants and the hex digit table.
// No dependencies.
`default_nettype none
package ufpe_pkg;

  localparam int UFPE_QUEUE_DEPTH = 4;

  localparam logic [6:0] CH_PCT   = 7'h25;
  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_DASH  = 7'h2D;
  localparam logic [6:0] CH_DOT   = 7'h2E;
  localparam logic [6:0] CH_UNDER = 7'h5F;
  localparam logic [6:0] CH_TILDE = 7'h7E;

  localparam logic [1:0] PH_PCT = 2'd0;
  localparam logic [1:0] PH_HI  = 2'd1;
  localparam logic [1:0] PH_LO  = 2'd2;

  typedef struct packed {
    logic            is_lit;
    logic [6:0]      lit;
    logic [1:0]      nbytes;
    logic [2:0][7:0] bytes;
    logic            str_end;
  } ufpe_desc_t;

  function automatic logic [6:0] hex_char(input logic [3:0] d);
    logic [6:0] c;
    unique case (d)
      4'h0: c = 7'h30;
      4'h1: c = 7'h31;
      4'h2: c = 7'h32;
      4'h3: c = 7'h33;
      4'h4: c = 7'h34;
      4'h5: c = 7'h35;
      4'h6: c = 7'h36;
      4'h7: c = 7'h37;
      4'h8: c = 7'h38;
      4'h9: c = 7'h39;
      4'hA: c = 7'h41;
      4'hB: c = 7'h42;
      4'hC: c = 7'h43;
      4'hD: c = 7'h44;
      4'hE: c = 7'h45;
      4'hF: c = 7'h46;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- sv/ufpe_front.sv -----
// Front end: classifies one code unit into a work descriptor.
// Depends on ufpe_pkg.
`default_nettype none
module ufpe_front
  import ufpe_pkg::*;
(
  input  wire logic [15:0] code_unit,
  input  wire logic        string_end,
  output ufpe_desc_t       desc
);

  logic [15:0] cu;
  logic [6:0]  a;
  logic        unres;

  always_comb begin
    a     = code_unit[6:0];
    unres = (a >= 7'h30 && a <= 7'h39) || (a >= 7'h41 && a <= 7'h5A) ||
            (a >= 7'h61 && a <= 7'h7A) || a == CH_DASH || a == CH_UNDER ||
            a == CH_DOT || a == CH_TILDE;
    cu = code_unit;
    if (code_unit >= 16'hD800 && code_unit <= 16'hDFFF) begin
      cu = 16'hFFFD;
    end
    desc.str_end = string_end;
    desc.is_lit  = 1'b0;
    desc.lit     = a;
    desc.nbytes  = 2'd1;
    desc.bytes   = '0;
    if (code_unit > 16'd127) begin
      if (cu < 16'h0800) begin
        desc.nbytes   = 2'd2;
        desc.bytes[0] = {3'b110, cu[10:6]};
        desc.bytes[1] = {2'b10, cu[5:0]};
      end else begin
        desc.nbytes   = 2'd3;
        desc.bytes[0] = {4'b1110, cu[15:12]};
        desc.bytes[1] = {2'b10, cu[11:6]};
        desc.bytes[2] = {2'b10, cu[5:0]};
      end
    end else if (unres) begin
      desc.is_lit = 1'b1;
    end else if (a == CH_SPACE) begin
      desc.is_lit = 1'b1;
      desc.lit    = CH_PLUS;
    end else begin
      desc.bytes[0] = {1'b0, a};
    end
  end

endmodule
`default_nettype wire

// ----- sv/ufpe_queue.sv -----
// Short descriptor queue between the front end and the serializer.
// Depends on ufpe_pkg.
`default_nettype none
module ufpe_queue
  import ufpe_pkg::*;
#(
  parameter int DEPTH = UFPE_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  wire ufpe_desc_t wr_data,
  output logic      full,
  input  wire logic rd_en,
  output ufpe_desc_t rd_data,
  output logic      empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  ufpe_desc_t    mem_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == LAST_PTR) ? '0 : wptr_r + 1'b1;
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == LAST_PTR) ? '0 : rptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ----- sv/ufpe_back.sv -----
// Back end: walks each descriptor and emits one character per cycle while pop is high.
// Holds the output register. Depends on ufpe_pkg.
`default_nettype none
module ufpe_back
  import ufpe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire ufpe_desc_t head,
  input  wire logic       head_empty,
  output logic            head_pop,
  output logic            empty,
  input  wire logic       pop,
  output logic [6:0]      out_char,
  output logic            out_run_last,
  output logic            out_string_done
);

  logic [1:0] phase_r, phase_nxt;
  logic [1:0] bidx_r, bidx_nxt;
  logic       valid_r, valid_nxt;
  logic [6:0] char_r;
  logic       last_r, done_r;
  logic [6:0] char_c;
  logic       last_c;
  logic [7:0] cur_byte;
  logic       load;

  assign cur_byte = head.bytes[bidx_r];

  always_comb begin
    if (head.is_lit) begin
      char_c = head.lit;
      last_c = 1'b1;
    end else begin
      unique case (phase_r)
        PH_PCT:  char_c = CH_PCT;
        PH_HI:   char_c = hex_char(cur_byte[7:4]);
        PH_LO:   char_c = hex_char(cur_byte[3:0]);
        default: char_c = CH_PCT;
      endcase
      last_c = (phase_r == PH_LO) && (bidx_r == head.nbytes - 2'd1);
    end
  end

  assign load     = !head_empty && (!valid_r || pop);
  assign head_pop = load && last_c;

  always_comb begin
    phase_nxt = phase_r;
    bidx_nxt  = bidx_r;
    valid_nxt = valid_r;
    if (pop && valid_r) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
      if (last_c) begin
        phase_nxt = PH_PCT;
        bidx_nxt  = 2'd0;
      end else if (phase_r == PH_LO) begin
        phase_nxt = PH_PCT;
        bidx_nxt  = bidx_r + 2'd1;
      end else begin
        phase_nxt = phase_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PCT;
      bidx_r  <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      bidx_r  <= bidx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= char_c;
      last_r <= last_c;
      done_r <= last_c && head.str_end;
    end
  end

  assign empty           = !valid_r;
  assign out_char        = char_r;
  assign out_run_last    = last_r;
  assign out_string_done = done_r;

endmodule
`default_nettype wire

// ----- sv/url_form_percent_encoder_core.sv -----
// URL form percent encoder, top level.
// Instantiates ufpe_front, ufpe_queue and ufpe_back; depends on ufpe_pkg.
//
// Usage: the input side is a queue write port. A request (one UTF-16 code unit
// and its end-of-string flag) is taken on a clock edge where push is high and
// full is low. The result side is a queue read port: while empty is low the
// oldest encoded character is on out_char with out_run_last and
// out_string_done, and it is taken on an edge where pop is high.
// Each request yields one to nine characters: unreserved ASCII and space give
// one, other ASCII gives three, other code units give six or nine.
// The first character reaches the result ports through the descriptor queue
// and then the output register. The serializer emits one character per cycle
// while pop is high and a descriptor is waiting; the descriptor queue of
// QUEUE_DEPTH entries lets the input keep accepting while the serializer works
// through a request, and full rises when it fills.
// When the receiver stalls, the output register holds its character and the
// queue fills behind it. Synchronous reset empties the queue and the output
// register and returns the serializer to the start of a descriptor.
`default_nettype none
module url_form_percent_encoder_core
  import ufpe_pkg::*;
#(
  parameter int QUEUE_DEPTH = UFPE_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] in_code_unit,
  input  wire logic        in_string_end,
  output logic             empty,
  input  wire logic        pop,
  output logic [6:0]       out_char,
  output logic             out_run_last,
  output logic             out_string_done
);

  ufpe_desc_t front_desc;
  ufpe_desc_t head_desc;
  logic       head_empty;
  logic       head_pop;

  ufpe_front u_front (
    .code_unit  (in_code_unit),
    .string_end (in_string_end),
    .desc       (front_desc)
  );

  ufpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (front_desc),
    .full    (full),
    .rd_en   (head_pop),
    .rd_data (head_desc),
    .empty   (head_empty)
  );

  ufpe_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head_desc),
    .head_empty      (head_empty),
    .head_pop        (head_pop),
    .empty           (empty),
    .pop             (pop),
    .out_char        (out_char),
    .out_run_last    (out_run_last),
    .out_string_done (out_string_done)
  );

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Testbench for url_form_percent_encoder_core: directed and random code units are
// pushed in, and each popped character is checked against a local encoder model.
// Depends on ufpe_pkg for the character constants and on the core itself.
`timescale 1ns / 100ps
module testbench
  import ufpe_pkg::*;
;

  typedef struct packed {
    logic [6:0] ch;
    logic       run_last;
    logic       str_done;
  } enc_char_t;

  localparam int STALL_LIMIT = 500;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [15:0] in_code_unit = 16'h0000;
  logic        in_string_end = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [6:0]  out_char;
  logic        out_run_last;
  logic        out_string_done;

  enc_char_t   expected_chars[$];
  int          error_count = 0;
  int          quiet_cycles = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;

  url_form_percent_encoder_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_code_unit    (in_code_unit),
    .in_string_end   (in_string_end),
    .empty           (empty),
    .pop             (pop),
    .out_char        (out_char),
    .out_run_last    (out_run_last),
    .out_string_done (out_string_done)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [6:0] hex_digit(input logic [3:0] d);
    return (d < 4'd10) ? (7'h30 + {3'b000, d}) : (7'h37 + {3'b000, d});
  endfunction

  function automatic bit is_unreserved(input logic [6:0] c);
    return (c >= 7'h30 && c <= 7'h39) || (c >= 7'h41 && c <= 7'h5A) ||
           (c >= 7'h61 && c <= 7'h7A) || c == CH_DASH || c == CH_UNDER ||
           c == CH_DOT || c == CH_TILDE;
  endfunction

  function automatic void predict_encoding(input logic [15:0] cu, input logic str_end);
    logic [15:0] c;
    logic [7:0]  utf_bytes[3];
    logic [6:0]  chars[9];
    int          n_bytes;
    int          n_chars;
    enc_char_t   e;
    c = cu;
    n_bytes = 0;
    n_chars = 0;
    if (c > 16'd127) begin
      if (c >= 16'hD800 && c <= 16'hDFFF) c = 16'hFFFD;
      if (c < 16'h0800) begin
        utf_bytes[0] = 8'hC0 | {3'b000, c[10:6]};
        utf_bytes[1] = 8'h80 | {2'b00, c[5:0]};
        n_bytes = 2;
      end else begin
        utf_bytes[0] = 8'hE0 | {4'b0000, c[15:12]};
        utf_bytes[1] = 8'h80 | {2'b00, c[11:6]};
        utf_bytes[2] = 8'h80 | {2'b00, c[5:0]};
        n_bytes = 3;
      end
    end else if (is_unreserved(c[6:0])) begin
      chars[0] = c[6:0];
      n_chars = 1;
    end else if (c[6:0] == CH_SPACE) begin
      chars[0] = CH_PLUS;
      n_chars = 1;
    end else begin
      utf_bytes[0] = c[7:0];
      n_bytes = 1;
    end
    for (int i = 0; i < n_bytes; i++) begin
      chars[n_chars]     = CH_PCT;
      chars[n_chars + 1] = hex_digit(utf_bytes[i][7:4]);
      chars[n_chars + 2] = hex_digit(utf_bytes[i][3:0]);
      n_chars += 3;
    end
    for (int i = 0; i < n_chars; i++) begin
      e.ch       = chars[i];
      e.run_last = (i == n_chars - 1);
      e.str_done = (i == n_chars - 1) && str_end;
      expected_chars = {expected_chars, e};
    end
  endfunction

  function automatic logic [15:0] random_code_unit();
    logic [15:0] c;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: c = 16'($urandom_range(16'h41, 16'h5A));
          1: c = 16'($urandom_range(16'h61, 16'h7A));
          2: c = 16'($urandom_range(16'h30, 16'h39));
          default: begin
            case ($urandom_range(0, 3))
              0: c = {9'd0, CH_DASH};
              1: c = {9'd0, CH_UNDER};
              2: c = {9'd0, CH_DOT};
              default: c = {9'd0, CH_TILDE};
            endcase
          end
        endcase
      end
      1: c = {9'd0, CH_SPACE};
      2: c = 16'($urandom_range(0, 127));
      3: c = 16'($urandom_range(16'h0080, 16'h07FF));
      4: begin
        if ($urandom_range(0, 1) == 0) c = 16'($urandom_range(16'h0800, 16'hD7FF));
        else c = 16'($urandom_range(16'hE000, 16'hFFFF));
      end
      5: c = 16'($urandom_range(16'hD800, 16'hDFFF));
      default: c = 16'($urandom_range(0, 16'hFFFF));
    endcase
    return c;
  endfunction

  // Push is left high after a request unless an idle burst follows, so that
  // back-to-back requests never lower and raise it within one time step.
  task automatic send_code_unit(input logic [15:0] cu, input logic str_end);
    in_code_unit  <= cu;
    in_string_end <= str_end;
    push          <= 1'b1;
    do @(posedge clk); while (full);
    predict_encoding(cu, str_end);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic send_string(input int len);
    for (int i = 0; i < len; i++) send_code_unit(random_code_unit(), i == len - 1);
  endtask

  task automatic test_directed_cases();
    logic [15:0] cases[$];
    cases = '{16'h0000, 16'h0041, 16'h007A, 16'h0030, 16'h0039, {9'd0, CH_DASH},
              {9'd0, CH_UNDER}, {9'd0, CH_DOT}, {9'd0, CH_TILDE}, {9'd0, CH_SPACE},
              {9'd0, CH_PLUS}, {9'd0, CH_PCT}, 16'h002F, 16'h007F, 16'h0080, 16'h07FF,
              16'h0800, 16'hD7FF, 16'hD800, 16'hDC00, 16'hDFFF, 16'hE000, 16'hFFFD,
              16'hFFFF};
    foreach (cases[i]) send_code_unit(cases[i], i[0]);
  endtask

  task automatic test_random_strings(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 12);
      send_string(len);
      sent += len;
    end
  endtask

  task automatic test_random_noise(input int n_items);
    for (int i = 0; i < n_items; i++) begin
      send_code_unit(16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_back_to_back(input int n_items);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_strings(n_items);
  endtask

  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character: actual %h", out_char);
        error_count++;
      end else begin
        enc_char_t e;
        e = expected_chars.pop_front();
        if (out_char !== e.ch) begin
          $error("out_char: expected %h, actual %h", e.ch, out_char);
          error_count++;
        end
        if (out_run_last !== e.run_last) begin
          $error("out_run_last: expected %b, actual %b", e.run_last, out_run_last);
          error_count++;
        end
        if (out_string_done !== e.str_done) begin
          $error("out_string_done: expected %b, actual %b", e.str_done, out_string_done);
          error_count++;
        end
      end
    end
    if ((rst_n && pop && !empty) || (push && !full)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_strings(270);
    test_random_noise(60);
    test_back_to_back(80);
    push <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
